// ----- sv/lsh_pkg.sv -----
// Shared types, constants and register codes of the Laplacian sharpening block.
`default_nettype none
package lsh_pkg;

    localparam int PIXEL_BITS    = 16;
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_HEIGHT    = 4096;

    localparam int CFG_WIDTH_W  = 11;
    localparam int CFG_HEIGHT_W = 13;
    localparam int CFG_GAIN_W   = 16;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_INDEX_W  = 2;
    localparam int ROW_W        = 12;

    localparam int FRAC_BITS = 12;

    localparam logic [CFG_WIDTH_W-1:0]  RST_FRAME_WIDTH  = CFG_WIDTH_W'(256);
    localparam logic [CFG_HEIGHT_W-1:0] RST_FRAME_HEIGHT = CFG_HEIGHT_W'(256);
    localparam logic [CFG_GAIN_W-1:0]   RST_SHARPEN_GAIN = '0;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_SHARPEN_GAIN = 2'd2
    } lsh_reg_t;

    typedef enum logic [1:0] {
        LSH_PRIME_CUR,
        LSH_PRIME_NEXT,
        LSH_RUN
    } lsh_state_t;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel_in;
        logic                  fill_item;
    } lsh_in_t;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel_out;
        logic                  clamped;
        logic                  frame_end;
    } lsh_out_t;

    // One column of the line buffers: row above and center row.
    typedef struct packed {
        logic [PIXEL_BITS-1:0] above;
        logic [PIXEL_BITS-1:0] center;
    } lsh_word_t;

    // Neighborhood handed from the scan control to the arithmetic pipe.
    typedef struct packed {
        logic                  valid;
        logic                  border;
        logic                  frame_end;
        logic [PIXEL_BITS-1:0] p;
        logic [PIXEL_BITS-1:0] l;
        logic [PIXEL_BITS-1:0] r;
        logic [PIXEL_BITS-1:0] u;
        logic [PIXEL_BITS-1:0] d;
    } lsh_issue_t;

endpackage
`default_nettype wire

// ----- sv/laplacian_sharpen_3x3_core.sv -----
// Top level of the 3x3 Laplacian sharpening block.
//
// Takes a raster pixel stream and returns each pixel one row late as
// p + gain*(4p - left - right - up - down), gain in signed Q4.12, rounded
// half up and clamped to 16 bits with a clamp flag; border pixels pass
// unchanged. The first row of a frame gives no results; after the last
// pixel the host sends frame_width fill items, which return the last row,
// the final one marked frame_end. Fill items outside that drain are
// dropped. One item per clock is sustained while res_stall is low: both
// line buffers live in one dual-port memory (read-ahead of the next column,
// write-back of the current one), and results come out through a
// registered, stall-aware pipe that keeps accepting while a stage is free.
// After reset and after every frame_width write the block primes the
// read-ahead in PRIME_CUR and PRIME_NEXT before it takes pixels. Write
// configuration only between frames while no item is in flight.
`default_nettype none
module laplacian_sharpen_3x3_core #(
    parameter int MAX_WIDTH = lsh_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // pixel items
    input  wire logic                              px_valid,
    output logic                                   px_stall,
    input  wire lsh_pkg::lsh_in_t                  px_data,
    // result items
    output logic                                   res_valid,
    input  wire logic                              res_stall,
    output lsh_pkg::lsh_out_t                      res_data,
    // configuration writes
    input  wire logic                              cfg_we,
    input  wire logic [lsh_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [lsh_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH);

    logic [lsh_pkg::CFG_WIDTH_W-1:0]  frame_width_reg;
    logic [lsh_pkg::CFG_HEIGHT_W-1:0] frame_height_reg;
    logic [lsh_pkg::CFG_GAIN_W-1:0]   sharpen_gain_reg;
    logic                             width_wr;

    logic               rd_en, wr_en, pipe_ready;
    logic [AW-1:0]      rd_addr, wr_addr;
    lsh_pkg::lsh_word_t rd_data, wr_data;
    lsh_pkg::lsh_issue_t issue;

    // Register file; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= lsh_pkg::RST_FRAME_WIDTH;
            frame_height_reg <= lsh_pkg::RST_FRAME_HEIGHT;
            sharpen_gain_reg <= lsh_pkg::RST_SHARPEN_GAIN;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lsh_pkg::REG_FRAME_WIDTH:
                    frame_width_reg <= cfg_data[lsh_pkg::CFG_WIDTH_W-1:0];
                lsh_pkg::REG_FRAME_HEIGHT:
                    frame_height_reg <= cfg_data[lsh_pkg::CFG_HEIGHT_W-1:0];
                lsh_pkg::REG_SHARPEN_GAIN:
                    sharpen_gain_reg <= cfg_data[lsh_pkg::CFG_GAIN_W-1:0];
                default:
                    frame_width_reg <= frame_width_reg;
            endcase
        end
    end

    // A new width invalidates the column read-ahead.
    assign width_wr = cfg_we && (cfg_index == lsh_pkg::REG_FRAME_WIDTH);

    lsh_scan_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .px_valid     (px_valid),
        .px_data      (px_data),
        .px_stall     (px_stall),
        .pipe_ready   (pipe_ready),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .width_wr     (width_wr),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .issue        (issue)
    );

    // Above row and center row, side by side in one word per column.
    lsh_line_mem #(
        .DEPTH (MAX_WIDTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    lsh_sharpen_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .issue     (issue),
        .ready     (pipe_ready),
        .gain      ($signed(sharpen_gain_reg)),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

endmodule
`default_nettype wire

// ----- sv/lsh_line_mem.sv -----
// Line buffer memory: one write port, one read port with registered read data.
`default_nettype none
module lsh_line_mem #(
    parameter int DEPTH = lsh_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire lsh_pkg::lsh_word_t       wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output lsh_pkg::lsh_word_t            rd_data
);

    lsh_pkg::lsh_word_t mem [DEPTH];
    lsh_pkg::lsh_word_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ----- sv/lsh_scan_ctrl.sv -----
// Raster scan control: counters, line buffer read-ahead and write-back.
`default_nettype none
module lsh_scan_ctrl #(
    parameter int MAX_WIDTH = lsh_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  px_valid,
    input  wire lsh_pkg::lsh_in_t                      px_data,
    output logic                                       px_stall,
    input  wire logic                                  pipe_ready,
    input  wire logic [lsh_pkg::CFG_WIDTH_W-1:0]       frame_width,
    input  wire logic [lsh_pkg::CFG_HEIGHT_W-1:0]      frame_height,
    input  wire logic                                  width_wr,
    output logic                                       rd_en,
    output logic [$clog2(MAX_WIDTH)-1:0]               rd_addr,
    input  wire lsh_pkg::lsh_word_t                    rd_data,
    output logic                                       wr_en,
    output logic [$clog2(MAX_WIDTH)-1:0]               wr_addr,
    output lsh_pkg::lsh_word_t                         wr_data,
    output lsh_pkg::lsh_issue_t                        issue
);

    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int WREQ = $clog2(MAX_WIDTH + 1);
    localparam int WW   = (WREQ > lsh_pkg::CFG_WIDTH_W) ? WREQ : lsh_pkg::CFG_WIDTH_W;
    localparam int SW   = WW + 1;
    localparam int HW   = lsh_pkg::CFG_HEIGHT_W;
    localparam int RW   = lsh_pkg::ROW_W;

    lsh_pkg::lsh_state_t state_reg, state_next;

    logic [AW-1:0]                   col_reg, col_next;
    logic [RW-1:0]                   row_reg, row_next;
    logic                            drain_reg, drain_next;
    logic [lsh_pkg::PIXEL_BITS-1:0]  left_reg, left_next;
    lsh_pkg::lsh_word_t              cur_reg, cur_next;

    logic [WW-1:0] fw_ext, wc, col_c, wc_last;
    logic [HW-1:0] hc, row_c;
    logic [SW-1:0] col_p1, col_p2, look_cur1, look_next2;
    logic          running, prime_rd, prime_load, prime_second;
    logic          accept, step, pixel_step;

    // Clamp the size registers to their legal ranges.
    always_comb
    begin
        fw_ext = WW'(frame_width);
        if (fw_ext < WW'(3))
            wc = WW'(3);
        else if (fw_ext > WW'(MAX_WIDTH))
            wc = WW'(MAX_WIDTH);
        else
            wc = fw_ext;
        if (frame_height < HW'(3))
            hc = HW'(3);
        else if (frame_height > HW'(lsh_pkg::MAX_HEIGHT))
            hc = HW'(lsh_pkg::MAX_HEIGHT);
        else
            hc = frame_height;
        wc_last = wc - WW'(1);
        col_c   = (WW'(col_reg) >= wc) ? wc_last : WW'(col_reg);
        row_c   = (HW'(row_reg) >= hc) ? (hc - HW'(1)) : HW'(row_reg);
        col_p1  = SW'(col_c) + SW'(1);
        col_p2  = SW'(col_c) + SW'(2);
        look_cur1  = (col_p1 >= SW'(wc)) ? '0 : col_p1;
        look_next2 = (col_p2 >= SW'(wc)) ? (col_p2 - SW'(wc)) : col_p2;
    end

    // Read-ahead priming after reset or a width change.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lsh_pkg::LSH_PRIME_CUR:  state_next = lsh_pkg::LSH_PRIME_NEXT;
            lsh_pkg::LSH_PRIME_NEXT: state_next = lsh_pkg::LSH_RUN;
            lsh_pkg::LSH_RUN:        state_next = lsh_pkg::LSH_RUN;
            default:                 state_next = lsh_pkg::LSH_PRIME_CUR;
        endcase
        if (width_wr)
            state_next = lsh_pkg::LSH_PRIME_CUR;
    end

    always_comb
    begin
        running      = 1'b0;
        prime_rd     = 1'b0;
        prime_load   = 1'b0;
        prime_second = 1'b0;
        case (state_reg)
            lsh_pkg::LSH_PRIME_CUR:
            begin
                prime_rd = 1'b1;
            end
            lsh_pkg::LSH_PRIME_NEXT:
            begin
                prime_rd     = 1'b1;
                prime_load   = 1'b1;
                prime_second = 1'b1;
            end
            lsh_pkg::LSH_RUN:
            begin
                running = 1'b1;
            end
            default:
            begin
                running = 1'b0;
            end
        endcase
    end

    assign px_stall   = !(running && pipe_ready);
    assign accept     = px_valid && !px_stall;
    assign step       = accept && (drain_reg || !px_data.fill_item);
    assign pixel_step = step && !drain_reg;

    // cur_reg holds column col_c, rd_data holds column col_c+1.
    always_comb
    begin
        rd_en = prime_rd || step;
        if (prime_rd && !prime_second)
            rd_addr = col_c[AW-1:0];
        else if (prime_second)
            rd_addr = look_cur1[AW-1:0];
        else
            rd_addr = look_next2[AW-1:0];
    end

    assign wr_en          = pixel_step;
    assign wr_addr        = col_c[AW-1:0];
    assign wr_data.above  = cur_reg.center;
    assign wr_data.center = px_data.pixel_in;

    always_comb
    begin
        issue.valid     = accept && (drain_reg || (!px_data.fill_item && (row_c != '0)));
        issue.border    = drain_reg || (col_c == '0) || (col_c == wc_last)
                          || (row_c == HW'(1));
        issue.frame_end = drain_reg && (col_c == wc_last);
        issue.p         = cur_reg.center;
        issue.l         = left_reg;
        issue.r         = rd_data.center;
        issue.u         = cur_reg.above;
        issue.d         = px_data.pixel_in;
    end

    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        drain_next = drain_reg;
        left_next  = left_reg;
        cur_next   = cur_reg;
        if (prime_load)
            cur_next = rd_data;
        if (step)
        begin
            cur_next = rd_data;
            if (!drain_reg)
                left_next = cur_reg.center;
            if (col_p1 >= SW'(wc))
            begin
                col_next = '0;
                if (drain_reg)
                begin
                    row_next   = '0;
                    drain_next = 1'b0;
                end
                else if ((row_c + HW'(1)) >= hc)
                begin
                    row_next   = '0;
                    drain_next = 1'b1;
                end
                else
                begin
                    row_next = RW'(row_c + HW'(1));
                end
            end
            else
            begin
                col_next = col_p1[AW-1:0];
                row_next = RW'(row_c);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lsh_pkg::LSH_PRIME_CUR;
            col_reg   <= '0;
            row_reg   <= '0;
            drain_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            drain_reg <= drain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg <= left_next;
        cur_reg  <= cur_next;
    end

endmodule
`default_nettype wire

// ----- sv/lsh_sharpen_pipe.sv -----
// Three-stage sharpening arithmetic: Laplacian, gain product, round and clamp.
`default_nettype none
module lsh_sharpen_pipe (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire lsh_pkg::lsh_issue_t                  issue,
    output logic                                      ready,
    input  wire logic signed [lsh_pkg::CFG_GAIN_W-1:0] gain,
    output logic                                      res_valid,
    input  wire logic                                 res_stall,
    output lsh_pkg::lsh_out_t                         res_data
);

    localparam int PB = lsh_pkg::PIXEL_BITS;
    localparam int LW = PB + 3;
    localparam int PW = lsh_pkg::CFG_GAIN_W + LW;
    localparam int QW = PW - lsh_pkg::FRAC_BITS;
    localparam int VW = QW + 1;

    logic en1, en2, en3;

    logic                 v1_reg, v2_reg, v3_reg;
    logic                 b1_reg, b2_reg;
    logic                 fe1_reg, fe2_reg;
    logic [PB-1:0]        p1_reg, p2_reg;
    logic signed [LW-1:0] lap_reg, lap_next;
    logic signed [PW-1:0] prod_reg, prod_next;
    lsh_pkg::lsh_out_t    out_reg, out_next;

    logic signed [PW-1:0] rnd;
    logic signed [QW-1:0] q;
    logic signed [VW-1:0] v;

    assign en3   = !v3_reg || !res_stall;
    assign en2   = !v2_reg || en3;
    assign en1   = !v1_reg || en2;
    assign ready = en1;

    // 4p - l - r - u - d, exact.
    assign lap_next = $signed({1'b0, issue.p, 2'b00})
                      - $signed({3'b000, issue.l}) - $signed({3'b000, issue.r})
                      - $signed({3'b000, issue.u}) - $signed({3'b000, issue.d});

    assign prod_next = gain * lap_reg;

    // Round half up, floor shift, add to p, clamp.
    always_comb
    begin
        rnd = prod_reg + PW'(1 << (lsh_pkg::FRAC_BITS - 1));
        q   = rnd[PW-1:lsh_pkg::FRAC_BITS];
        v   = $signed({{(VW-PB){1'b0}}, p2_reg}) + VW'(q);
        out_next.frame_end = fe2_reg;
        if (b2_reg)
        begin
            out_next.pixel_out = p2_reg;
            out_next.clamped   = 1'b0;
        end
        else if (v[VW-1])
        begin
            out_next.pixel_out = '0;
            out_next.clamped   = 1'b1;
        end
        else if (|v[VW-2:PB])
        begin
            out_next.pixel_out = '1;
            out_next.clamped   = 1'b1;
        end
        else
        begin
            out_next.pixel_out = v[PB-1:0];
            out_next.clamped   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= issue.valid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            b1_reg  <= issue.border;
            fe1_reg <= issue.frame_end;
            p1_reg  <= issue.p;
            lap_reg <= lap_next;
        end
        if (en2)
        begin
            b2_reg   <= b1_reg;
            fe2_reg  <= fe1_reg;
            p2_reg   <= p1_reg;
            prod_reg <= prod_next;
        end
        if (en3)
        begin
            out_reg <= out_next;
        end
    end

    assign res_valid = v3_reg;
    assign res_data  = out_reg;

endmodule
`default_nettype wire
